/* hw/rtl/barometer_compensation_macros.svh */
// Assertion macros for the barometer compensation block.
`ifndef BAROMETER_COMPENSATION_MACROS_SVH
`define BAROMETER_COMPENSATION_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define BC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another one on the next edge.
`define BC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define BC_ASSERT(lbl, prop, msg)
`define BC_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

/* hw/rtl/baro_pkg.sv */
// Package with item types, register indexes and sequencer codes.
`timescale 1ns / 1ps
package baro_pkg;

  typedef struct packed {
    logic        req_type;
    logic [18:0] raw_sample;
  } baro_in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               div_error;
  } baro_out_t;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MC_MD   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OSS     = 3'd5;

  localparam logic REQ_TEMP = 1'b0;
  localparam logic REQ_PRES = 1'b1;

  localparam logic [31:0] K_B6_OFS  = 32'd4000;
  localparam logic [31:0] K_B7_SCL  = 32'd50000;
  localparam logic [31:0] K_C3038   = 32'd3038;
  localparam logic [31:0] K_CM7357  = 32'hFFFF_E343;
  localparam logic [31:0] K_C3791   = 32'd3791;
  localparam logic [31:0] K_B4_OFS  = 32'd32768;
  localparam logic [31:0] K_SIGN    = 32'h8000_0000;

  localparam int StW = 5;
  localparam logic [StW-1:0] S_IDLE = 5'd0;
  localparam logic [StW-1:0] S_T0   = 5'd1;
  localparam logic [StW-1:0] S_T1   = 5'd2;
  localparam logic [StW-1:0] S_T2   = 5'd3;
  localparam logic [StW-1:0] S_P0   = 5'd4;
  localparam logic [StW-1:0] S_P1   = 5'd5;
  localparam logic [StW-1:0] S_P2   = 5'd6;
  localparam logic [StW-1:0] S_P3   = 5'd7;
  localparam logic [StW-1:0] S_P4   = 5'd8;
  localparam logic [StW-1:0] S_P5   = 5'd9;
  localparam logic [StW-1:0] S_P6   = 5'd10;
  localparam logic [StW-1:0] S_P7   = 5'd11;
  localparam logic [StW-1:0] S_P8   = 5'd12;
  localparam logic [StW-1:0] S_P9   = 5'd13;
  localparam logic [StW-1:0] S_P10  = 5'd14;
  localparam logic [StW-1:0] S_P11  = 5'd15;
  localparam logic [StW-1:0] S_P12  = 5'd16;
  localparam logic [StW-1:0] S_P13  = 5'd17;
  localparam logic [StW-1:0] S_P14  = 5'd18;
  localparam logic [StW-1:0] S_P15  = 5'd19;
  localparam logic [StW-1:0] S_P16  = 5'd20;
  localparam logic [StW-1:0] S_DIV  = 5'd21;
  localparam logic [StW-1:0] S_DONE = 5'd22;

endpackage

/* hw/rtl/barometer_compensation.sv */
// Barometer compensation top level: sequencer, shared multiplier and divider.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    baro_in_t  (req_type, raw_sample)
//   out_     output     out_valid/out_stall  baro_out_t (kind, temp, pressure, error)
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// Each item runs through the sequencer states from acceptance to result, and the
// sequencer returns to idle before the next item is taken. The divider gives one
// quotient bit per cycle, the other steps use at most one multiply each; a zero
// divisor skips the divide, for temperature and for pressure.
// Reset (rst_n low, synchronous) clears calibration, stored B5 and control.
// A new item is taken as soon as the sequencer is idle, even while a result
// still waits in the output register; a stalled output holds the sequencer.
`timescale 1ns / 1ps
`include "barometer_compensation_macros.svh"
module barometer_compensation (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  baro_pkg::baro_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output baro_pkg::baro_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [baro_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [baro_pkg::CfgDataW-1:0]    cfg_data
);
  import baro_pkg::*;

  // calibration registers
  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [1:0]  oss_r;
  logic [31:0] b5_r;

  // sequencer and working registers
  logic [StW-1:0] st_r;
  logic           kind_r;
  logic [18:0]    raw_r;
  logic [31:0]    t1_r, t2_r, b6_r, sq_r, b3_r, b4_r, b7_r, p_r;
  logic [15:0]    rtemp_r;
  logic           rerr_r;

  // divider
  logic [31:0] rem_r, quo_r, dvs_r;
  logic [4:0]  dcnt_r;
  logic        neg_r;

  logic            out_valid_r;
  baro_out_t       out_r;

  // calibration halves
  logic [31:0] ac1_s, ac2_s, ac3_s, ac4_u, ac5_u, ac6_u, b1_s, b2_s, mc_s, md_s;
  assign ac1_s = {{16{ac12_r[31]}}, ac12_r[31:16]};
  assign ac2_s = {{16{ac12_r[15]}}, ac12_r[15:0]};
  assign ac3_s = {{16{ac34_r[31]}}, ac34_r[31:16]};
  assign ac4_u = {16'd0, ac34_r[15:0]};
  assign ac5_u = {16'd0, ac56_r[31:16]};
  assign ac6_u = {16'd0, ac56_r[15:0]};
  assign b1_s  = {{16{b12_r[31]}}, b12_r[31:16]};
  assign b2_s  = {{16{b12_r[15]}}, b12_r[15:0]};
  assign mc_s  = {{16{mcmd_r[31]}}, mcmd_r[31:16]};
  assign md_s  = {{16{mcmd_r[15]}}, mcmd_r[15:0]};

  logic [31:0] raw_ext;
  assign raw_ext = {13'd0, raw_r};

  // shared multiplier operand selection
  logic [31:0] mul_a, mul_b, prod;
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (st_r)
      S_T0:  begin mul_a = raw_ext - ac6_u; mul_b = ac5_u; end
      S_P1:  begin mul_a = b6_r;  mul_b = b6_r; end
      S_P2:  begin mul_a = b2_s;  mul_b = sq_r; end
      S_P3:  begin mul_a = ac2_s; mul_b = b6_r; end
      S_P5:  begin mul_a = ac3_s; mul_b = b6_r; end
      S_P6:  begin mul_a = b1_s;  mul_b = sq_r; end
      S_P8:  begin mul_a = ac4_u; mul_b = t1_r + K_B4_OFS; end
      S_P9:  begin mul_a = raw_ext - b3_r; mul_b = K_B7_SCL >> oss_r; end
      S_P13: begin mul_a = t1_r;  mul_b = t1_r; end
      S_P14: begin mul_a = t1_r;  mul_b = K_C3038; end
      S_P15: begin mul_a = K_CM7357; mul_b = p_r; end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // divider step
  logic [32:0] dsh, ddif;
  logic        dfit;
  assign dsh  = {rem_r, quo_r[31]};
  assign ddif = dsh - {1'b0, dvs_r};
  assign dfit = !ddif[32];

  // misc datapath
  logic [31:0] den, mcsh, qsig, b5n, tsh, b3sum, x3n, pfin;
  assign den   = t1_r + md_s;
  assign mcsh  = mc_s << 11;
  assign qsig  = neg_r ? (32'd0 - quo_r) : quo_r;
  assign b5n   = t1_r + qsig;
  assign tsh   = 32'($signed(b5n + 32'd8) >>> 4);
  assign b3sum = 32'($signed(((ac1_s << 2) + t1_r + t2_r) << oss_r) + 32'sd2) >>> 2;
  assign x3n   = 32'($signed(t1_r + t2_r + 32'd2) >>> 2);
  assign pfin  = p_r + 32'($signed(t1_r + t2_r + K_C3791) >>> 4);

  logic [15:0] tsat;
  always_comb begin
    if (!tsh[31] && tsh[30:15] != 16'd0) tsat = 16'h7FFF;
    else if (tsh[31] && tsh[30:15] != 16'hFFFF) tsat = 16'h8000;
    else tsat = tsh[15:0];
  end

  logic in_acc, out_free;
  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac12_r <= '0; ac34_r <= '0; ac56_r <= '0; b12_r <= '0; mcmd_r <= '0; oss_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AC1_AC2: ac12_r <= cfg_data;
        REG_AC3_AC4: ac34_r <= cfg_data;
        REG_AC5_AC6: ac56_r <= cfg_data;
        REG_B1_B2:   b12_r  <= cfg_data;
        REG_MC_MD:   mcmd_r <= cfg_data;
        REG_OSS:     oss_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // control: sequencer, stored B5, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      b5_r <= '0;
      out_valid_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_acc) st_r <= (in_data.req_type == REQ_TEMP) ? S_T0 : S_P0;
        S_T0:   st_r <= S_T1;
        S_T1:   begin st_r <= (den == 32'd0) ? S_DONE : S_DIV; dcnt_r <= '0; end
        S_T2:   begin b5_r <= b5n; st_r <= S_DONE; end
        S_P0:   st_r <= S_P1;
        S_P1:   st_r <= S_P2;
        S_P2:   st_r <= S_P3;
        S_P3:   st_r <= S_P4;
        S_P4:   st_r <= S_P5;
        S_P5:   st_r <= S_P6;
        S_P6:   st_r <= S_P7;
        S_P7:   st_r <= S_P8;
        S_P8:   st_r <= S_P9;
        S_P9:   st_r <= S_P10;
        S_P10:  begin st_r <= (b4_r == 32'd0) ? S_DONE : S_DIV; dcnt_r <= '0; end
        S_P11:  st_r <= S_P12;
        S_P12:  st_r <= S_P13;
        S_P13:  st_r <= S_P14;
        S_P14:  st_r <= S_P15;
        S_P15:  st_r <= S_P16;
        S_P16:  st_r <= S_DONE;
        S_DIV: begin
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd31) st_r <= (kind_r == REQ_TEMP) ? S_T2 : S_P11;
        end
        S_DONE: if (out_free) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
      // output register: loaded when the result is handed over, cleared once taken
      if (st_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (in_acc) begin
        kind_r <= in_data.req_type;
        raw_r <= in_data.raw_sample;
        rerr_r <= 1'b0;
        rtemp_r <= '0;
        p_r <= '0;
      end
      S_T0: t1_r <= 32'($signed(prod) >>> 15);
      S_T1: begin
        if (den == 32'd0) rerr_r <= 1'b1;
        neg_r <= mcsh[31] ^ den[31];
        rem_r <= '0;
        quo_r <= mcsh[31] ? (32'd0 - mcsh) : mcsh;
        dvs_r <= den[31] ? (32'd0 - den) : den;
      end
      S_T2:  rtemp_r <= tsat;
      S_P0:  b6_r <= b5_r - K_B6_OFS;
      S_P1:  sq_r <= 32'($signed(prod) >>> 12);
      S_P2:  t1_r <= 32'($signed(prod) >>> 11);
      S_P3:  t2_r <= 32'($signed(prod) >>> 11);
      S_P4:  b3_r <= b3sum;
      S_P5:  t1_r <= 32'($signed(prod) >>> 13);
      S_P6:  t2_r <= 32'($signed(prod) >>> 16);
      S_P7:  t1_r <= x3n;
      S_P8:  b4_r <= prod >> 15;
      S_P9:  b7_r <= prod;
      S_P10: begin
        if (b4_r == 32'd0) rerr_r <= 1'b1;
        neg_r <= 1'b0;
        rem_r <= '0;
        quo_r <= (b7_r < K_SIGN) ? (b7_r << 1) : b7_r;
        dvs_r <= b4_r;
      end
      S_P11: p_r  <= (b7_r < K_SIGN) ? quo_r : (quo_r << 1);
      S_P12: t1_r <= 32'($signed(p_r) >>> 8);
      S_P13: t1_r <= prod;
      S_P14: t1_r <= 32'($signed(prod) >>> 16);
      S_P15: t2_r <= 32'($signed(prod) >>> 16);
      S_P16: p_r  <= pfin;
      S_DIV: begin
        rem_r <= dfit ? ddif[31:0] : dsh[31:0];
        quo_r <= {quo_r[30:0], dfit};
      end
      S_DONE: if (out_free) begin
        out_r.result_kind <= kind_r;
        out_r.temperature_tenths <= rtemp_r;
        out_r.pressure_pa <= p_r;
        out_r.div_error <= rerr_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BC_ASSERT(a_err_zero,
    !(out_valid_r && out_r.div_error) ||
    (out_r.temperature_tenths == 16'sd0 && out_r.pressure_pa == 32'sd0),
    "error result with nonzero values")
  `BC_ASSERT(a_temp_nopres,
    !(out_valid_r && out_r.result_kind == REQ_TEMP) || out_r.pressure_pa == 32'sd0,
    "temperature result carries pressure")
  `BC_ASSERT_NEXT(a_acc_busy, in_valid && !in_stall, st_r != S_IDLE,
    "accepted item did not start the sequencer")
endmodule

/* verif/tb_barometer_compensation.sv */
// Self-checking testbench for the barometer compensation block.
`timescale 1ns / 1ps
module tb_barometer_compensation;
  import baro_pkg::*;

  // Expected compensation results, predicted from calibration and stored B5
  class baro_scoreboard;
    logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
    logic [1:0]  oss;
    logic [31:0] b5_held;
    baro_out_t   expected_q[$];
    int          errors;

    function new();
      ac1_ac2 = '0; ac3_ac4 = '0; ac5_ac6 = '0; b1_b2 = '0; mc_md = '0;
      oss = '0; b5_held = '0; errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
      case (idx)
        REG_AC1_AC2: ac1_ac2 = val;
        REG_AC3_AC4: ac3_ac4 = val;
        REG_AC5_AC6: ac5_ac6 = val;
        REG_B1_B2:   b1_b2 = val;
        REG_MC_MD:   mc_md = val;
        REG_OSS:     oss = val[1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] asr(logic [31:0] v, int n);
      return $signed(v) >>> n;
    endfunction

    function logic [31:0] sx16(logic [15:0] h);
      return {{16{h[15]}}, h};
    endfunction

    function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
      longint q;
      q = longint'($signed(a)) / longint'($signed(b));
      return q[31:0];
    endfunction

    // One item in, one compensated result out
    function baro_out_t compensate(baro_in_t it);
      logic [31:0] raw, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
      longint      t;
      baro_out_t   r;
      r = '0;
      r.result_kind = it.req_type;
      raw = {13'b0, it.raw_sample};
      if (it.req_type == REQ_TEMP) begin
        x1 = asr((raw - {16'b0, ac5_ac6[15:0]}) * {16'b0, ac5_ac6[31:16]}, 15);
        den = x1 + sx16(mc_md[15:0]);
        if (den == 0) begin
          r.div_error = 1'b1;
        end else begin
          x2 = sdiv(sx16(mc_md[31:16]) << 11, den);
          b5 = x1 + x2;
          b5_held = b5;
          t = longint'($signed(asr(b5 + 32'd8, 4)));
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          r.temperature_tenths = t[15:0];
        end
      end else begin
        b6 = b5_held - K_B6_OFS;
        sq = asr(b6 * b6, 12);
        x1 = asr(sx16(b1_b2[15:0]) * sq, 11);
        x2 = asr(sx16(ac1_ac2[15:0]) * b6, 11);
        x3 = x1 + x2;
        b3 = asr(((sx16(ac1_ac2[31:16]) * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = asr(sx16(ac3_ac4[31:16]) * b6, 13);
        x2 = asr(sx16(b1_b2[31:16]) * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = ({16'b0, ac3_ac4[15:0]} * (x3 + K_B4_OFS)) >> 15;
        b7 = (raw - b3) * (K_B7_SCL >> oss);
        if (b4 == 0) begin
          r.div_error = 1'b1;
        end else begin
          if (b7 < K_SIGN) p = (b7 * 32'd2) / b4;
          else p = (b7 / b4) * 32'd2;
          x1 = asr(p, 8);
          x1 = x1 * x1;
          x1 = asr(x1 * K_C3038, 16);
          x2 = asr(K_CM7357 * p, 16);
          p = p + asr(x1 + x2 + K_C3791, 4);
          r.pressure_pa = p;
        end
      end
      return r;
    endfunction

    function void note_input(baro_in_t it);
      expected_q.push_back(compensate(it));
    endfunction

    function void check_result(baro_out_t got);
      baro_out_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.result_kind !== exp_r.result_kind) begin
        $error("result_kind exp %0d got %0d", exp_r.result_kind, got.result_kind);
        errors++;
      end
      if (got.temperature_tenths !== exp_r.temperature_tenths) begin
        $error("temperature_tenths exp %0d got %0d",
               exp_r.temperature_tenths, got.temperature_tenths);
        errors++;
      end
      if (got.pressure_pa !== exp_r.pressure_pa) begin
        $error("pressure_pa exp %0d got %0d", exp_r.pressure_pa, got.pressure_pa);
        errors++;
      end
      if (got.div_error !== exp_r.div_error) begin
        $error("div_error exp %0d got %0d", exp_r.div_error, got.div_error);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  baro_in_t  in_data;
  baro_out_t out_data;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  baro_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  barometer_compensation dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Fail-safe against a hung handshake
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // Watch both channels; values seen here are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  // Receiver: random hold-off per item while idle_on is set, one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = idle_on ? $urandom_range(7, 0) : 0;
      if (hold_req) begin
        n = 400;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_item(logic kind, logic [18:0] raw);
    baro_in_t it;
    int gap;
    it.req_type = kind;
    it.raw_sample = raw;
    gap = idle_on ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Calibration write; cfg_we stays high across a burst and the caller drops it at the end
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_cal(logic [31:0] a12, a34, a56, b12, mcmd, logic [1:0] os);
    write_reg(REG_AC1_AC2, a12);
    write_reg(REG_AC3_AC4, a34);
    write_reg(REG_AC5_AC6, a56);
    write_reg(REG_B1_B2, b12);
    write_reg(REG_MC_MD, mcmd);
    write_reg(REG_OSS, {30'b0, os});
    cfg_we <= 1'b0;
  endtask

  // Mostly pressure items with plausible raw values, some temperature items, plus noise
  task automatic random_items(int count, logic [1:0] os);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(3, 0) == 0) begin
        send_item(1'($urandom_range(1, 0)), 19'($urandom()));
      end else if ($urandom_range(4, 0) == 0) begin
        send_item(REQ_TEMP, 19'($urandom_range(36000, 20000)));
      end else begin
        send_item(REQ_PRES, 19'($urandom_range(45000, 20000) << os));
      end
    end
  endtask

  initial begin
    logic [31:0] a12, a34, a56, b12, mcmd;
    logic [1:0] os;
    int ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: pressure before any temperature, and both zero divisors
    send_item(REQ_PRES, 19'd23843);
    send_item(REQ_TEMP, 19'd0);
    send_item(REQ_TEMP, 19'h7FFFF);
    send_item(REQ_PRES, 19'h7FFFF);
    send_item(REQ_PRES, 19'd0);
    drain();

    // Datasheet calibration, extremes of both fields at every oversampling
    for (int o = 0; o < 4; o++) begin
      load_cal({16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd32757, 16'd23153},
               {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, o[1:0]);
      send_item(REQ_TEMP, 19'd27898);
      send_item(REQ_PRES, 19'(23843 << o));
      send_item(REQ_PRES, 19'd0);
      send_item(REQ_PRES, 19'h7FFFF);
      send_item(REQ_TEMP, 19'hFFFF);
      send_item(REQ_PRES, 19'h40000);
      drain();
    end
    // Index past the register file must be ignored
    write_reg(REG_OSS + 3'd1, 32'hFFFF_FFFF);
    write_reg(REG_OSS + 3'd2, 32'h1234_5678);
    cfg_we <= 1'b0;
    send_item(REQ_TEMP, 19'd30000);
    drain();

    // Random phases over several calibration sets
    for (ph = 0; ph < 12; ph++) begin
      os = ph[1:0];
      case (ph % 6)
        0: begin
          a12 = {16'd408, 16'hFFB8}; a34 = {16'hC7D1, 16'd32741};
          a56 = {16'd32757, 16'd23153}; b12 = {16'd6190, 16'd4};
          mcmd = {16'hDDF9, 16'd2868};
        end
        1: begin
          a12 = 32'hFFFF_FFFF; a34 = 32'hFFFF_FFFF; a56 = 32'hFFFF_FFFF;
          b12 = 32'hFFFF_FFFF; mcmd = 32'hFFFF_FFFF;
        end
        2: begin
          a12 = 32'h7FFF_7FFF; a34 = 32'h7FFF_0001; a56 = 32'h0001_0000;
          b12 = 32'h8000_8000; mcmd = 32'h7FFF_8000;
        end
        3: begin
          a12 = 32'h0; a34 = 32'h0; a56 = 32'h0; b12 = 32'h0; mcmd = 32'h0;
        end
        default: begin
          a12 = $urandom(); a34 = $urandom(); a56 = $urandom();
          b12 = $urandom(); mcmd = $urandom();
        end
      endcase
      if (ph == 3) os = 2'd3;
      idle_on = (ph % 4) != 1;
      load_cal(a12, a34, a56, b12, mcmd, os);
      if (ph == 2) hold_req = 1'b1;
      random_items(70, os);
      if (ph == 4) begin
        // Let everything drain before resuming
        @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
      random_items(80, os);
      drain();
    end
    idle_on = 1'b1;

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
